@@ rtl/core/gfm_pkg.sv @@
`default_nettype none
package gfm_pkg;

	localparam int MAX_COLS  = 256;
	localparam int MAX_ROWS  = 256;
	localparam int COL_W     = $clog2(MAX_COLS);
	localparam int ROW_IDX_W = $clog2(MAX_ROWS);
	localparam int DIM_W     = 9;
	localparam int Q_W       = 24;
	localparam int CFG_W     = 24;
	localparam int CFG_IDX_W = 3;
	localparam int KIND_W    = 2;
	localparam int DIR_W     = 3;
	localparam int POS_W     = 34;
	localparam int VNUM_W    = 20;
	localparam int WORD_W    = 3;
	localparam int X0_W      = COL_W + Q_W;
	localparam int OFF_W     = Q_W + 1;

	localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_PATH_WIDTH  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_WALL_HEIGHT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_MESH_KIND   = 3'd4;

	localparam logic [KIND_W-1:0] KIND_FLOOR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CEIL  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_WALL  = 2'd2;

	localparam logic REQ_CELL = 1'b0;

	localparam logic [DIR_W-1:0] DIR_TOP    = 3'd0;
	localparam logic [DIR_W-1:0] DIR_BOTTOM = 3'd1;
	localparam logic [DIR_W-1:0] DIR_LEFT   = 3'd2;
	localparam logic [DIR_W-1:0] DIR_RIGHT  = 3'd3;
	localparam logic [DIR_W-1:0] DIR_FRONT  = 3'd4;
	localparam logic [DIR_W-1:0] DIR_BACK   = 3'd5;

	localparam logic [1:0] SLOT_BACK  = 2'd0;
	localparam logic [1:0] SLOT_FRONT = 2'd1;
	localparam logic [1:0] SLOT_LEFT  = 2'd2;
	localparam logic [1:0] SLOT_RIGHT = 2'd3;

	localparam logic [1:0] SGN_ZERO = 2'd0;
	localparam logic [1:0] SGN_POS  = 2'd1;
	localparam logic [1:0] SGN_NEG  = 2'd2;

	localparam logic [Q_W-1:0] INSET_Q = 24'd66;

	typedef struct packed {
		logic [1:0] sx;
		logic [1:0] sy;
		logic [1:0] sz;
	} csign_t;

	// Mask bits follow the slot order back, front, left, right.
	typedef struct packed {
		logic [3:0]       mask;
		logic             horiz;
		logic [DIR_W-1:0] hdir;
		logic [X0_W-1:0]  x0;
		logic [X0_W-1:0]  z0;
		logic             clear;
	} job_t;

	// Remainder by three through a reciprocal multiply; exact below 512.
	function automatic logic [1:0] mod3(input logic [DIM_W-1:0] n);
		logic [17:0] p;
		logic [10:0] t;
		begin
			p = 18'(n) * 18'd171;
			t = 11'(n) - 11'(p[17:9]) * 11'd3;
			return t[1:0];
		end
	endfunction

	function automatic logic word_bit(input logic [WORD_W-1:0] w, input logic [1:0] i);
		case (i)
			2'd0: return w[0];
			2'd1: return w[1];
			default: return w[2];
		endcase
	endfunction

	function automatic csign_t corner_sign(input logic [DIR_W-1:0] dir, input logic [1:0] k);
		csign_t r;
		begin
			r = '{SGN_ZERO, SGN_ZERO, SGN_ZERO};
			case (dir)
				DIR_TOP: begin
					r.sx = (k == 2'd0 || k == 2'd3) ? SGN_NEG : SGN_POS;
					r.sz = (k == 2'd0 || k == 2'd1) ? SGN_POS : SGN_NEG;
				end
				DIR_BOTTOM: begin
					r.sx = (k == 2'd0 || k == 2'd3) ? SGN_NEG : SGN_POS;
					r.sz = (k == 2'd0 || k == 2'd1) ? SGN_NEG : SGN_POS;
				end
				DIR_LEFT: begin
					r.sy = (k == 2'd0 || k == 2'd1) ? SGN_POS : SGN_NEG;
					r.sz = (k == 2'd0 || k == 2'd3) ? SGN_NEG : SGN_POS;
				end
				DIR_RIGHT: begin
					r.sy = (k == 2'd0 || k == 2'd1) ? SGN_POS : SGN_NEG;
					r.sz = (k == 2'd0 || k == 2'd3) ? SGN_POS : SGN_NEG;
				end
				DIR_FRONT: begin
					r.sx = (k == 2'd0 || k == 2'd3) ? SGN_NEG : SGN_POS;
					r.sy = (k == 2'd0 || k == 2'd1) ? SGN_POS : SGN_NEG;
				end
				DIR_BACK: begin
					r.sx = (k == 2'd0 || k == 2'd3) ? SGN_POS : SGN_NEG;
					r.sy = (k == 2'd0 || k == 2'd1) ? SGN_POS : SGN_NEG;
				end
				default: r = '{SGN_ZERO, SGN_ZERO, SGN_ZERO};
			endcase
			return r;
		end
	endfunction

	function automatic logic signed [OFF_W-1:0] signed_off(input logic [1:0] s,
			input logic [Q_W-1:0] mag);
		case (s)
			SGN_POS: return $signed({1'b0, mag});
			SGN_NEG: return -$signed({1'b0, mag});
			default: return '0;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] clamp_pos(input logic [POS_W-1:0] c,
			input logic signed [OFF_W-1:0] o);
		logic signed [POS_W+1:0] t;
		begin
			t = $signed({2'b00, c}) + (POS_W+2)'(o);
			if (t[POS_W+1])
				return '0;
			else if (t[POS_W])
				return '1;
			else
				return t[POS_W-1:0];
		end
	endfunction

endpackage
`default_nettype wire

@@ rtl/core/gfm_in_if.sv @@
`default_nettype none
interface gfm_in_if;
	logic valid;
	logic ready;
	logic req_type;
	logic cell_is_wall;
	modport source(output valid, output req_type, output cell_is_wall, input ready);
	modport sink(input valid, input req_type, input cell_is_wall, output ready);
endinterface
`default_nettype wire

@@ rtl/core/gfm_out_if.sv @@
`default_nettype none
interface gfm_out_if;
	import gfm_pkg::*;
	logic              valid;
	logic              ready;
	logic [DIR_W-1:0]  face_dir;
	logic [1:0]        corner;
	logic [POS_W-1:0]  pos_x;
	logic [POS_W-1:0]  pos_y;
	logic [POS_W-1:0]  pos_z;
	logic [VNUM_W-1:0] vertex_number;
	logic              last_of_item;
	modport source(output valid, output face_dir, output corner, output pos_x, output pos_y,
		output pos_z, output vertex_number, output last_of_item, input ready);
	modport sink(input valid, input face_dir, input corner, input pos_x, input pos_y,
		input pos_z, input vertex_number, input last_of_item, output ready);
endinterface
`default_nettype wire

@@ rtl/core/gfm_line_store.sv @@
`default_nettype none
module gfm_line_store (
	input  logic                         clk,
	input  logic                         rd_en,
	input  logic [gfm_pkg::COL_W-1:0]    rd_addr_a,
	input  logic [gfm_pkg::COL_W-1:0]    rd_addr_b,
	input  logic                         wr_en,
	input  logic [gfm_pkg::COL_W-1:0]    wr_addr,
	input  logic [gfm_pkg::WORD_W-1:0]   wr_data,
	output logic [gfm_pkg::WORD_W-1:0]   rd_data_a,
	output logic [gfm_pkg::WORD_W-1:0]   rd_data_b
);
	import gfm_pkg::*;

	// One word per column, one bit per row modulo three.
	logic [WORD_W-1:0] mem [MAX_COLS];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
	end

	// A read issued at the edge of a write to the same column takes the new word.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a <= (wr_en && wr_addr == rd_addr_a) ? wr_data : mem[rd_addr_a];
			rd_data_b <= (wr_en && wr_addr == rd_addr_b) ? wr_data : mem[rd_addr_b];
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/gfm_emitter.sv @@
`default_nettype none
module gfm_emitter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       job_valid,
	input  gfm_pkg::job_t              job,
	output logic                       job_ready,
	input  logic [gfm_pkg::Q_W-1:0]    path_width,
	input  logic [gfm_pkg::Q_W-1:0]    wall_height,
	gfm_out_if.source                  vert_out
);
	import gfm_pkg::*;

	job_t              job_q;
	logic              jv_q;
	logic [1:0]        k_q;
	logic [VNUM_W-1:0] vcount_q;

	logic                    va_valid_q;
	logic [DIR_W-1:0]        va_dir_q;
	logic [1:0]              va_corner_q;
	logic [POS_W-1:0]        va_cx_q, va_cy_q, va_cz_q;
	logic signed [OFF_W-1:0] va_ox_q, va_oy_q, va_oz_q;
	logic [VNUM_W-1:0]       va_vnum_q;
	logic                    va_last_q;

	logic                    out_en, va_take, issue, last_v;
	logic [1:0]              slot;
	logic [3:0]              rest;
	logic [DIR_W-1:0]        dir;
	logic [Q_W-1:0]          hp, hh, h, mag_xz;
	logic [POS_W-1:0]        x0e, z0e, xm, zm, xr, zf, cx, cy, cz;
	csign_t                  sg;

	assign out_en  = !vert_out.valid || vert_out.ready;
	assign va_take = !va_valid_q || out_en;
	assign issue   = jv_q && va_take;

	always_comb begin
		if (job_q.mask[0])
			slot = SLOT_BACK;
		else if (job_q.mask[1])
			slot = SLOT_FRONT;
		else if (job_q.mask[2])
			slot = SLOT_LEFT;
		else
			slot = SLOT_RIGHT;
	end

	assign rest      = job_q.mask & ~(4'b0001 << slot);
	assign last_v    = (k_q == 2'd3) && (rest == 4'b0000);
	assign job_ready = !jv_q || (issue && last_v);

	always_comb begin
		if (job_q.horiz)
			dir = job_q.hdir;
		else begin
			case (slot)
				SLOT_BACK:  dir = DIR_BACK;
				SLOT_FRONT: dir = DIR_FRONT;
				SLOT_LEFT:  dir = DIR_LEFT;
				default:    dir = DIR_RIGHT;
			endcase
		end
	end

	assign hp     = {1'b0, path_width[Q_W-1:1]};
	assign hh     = {1'b0, wall_height[Q_W-1:1]};
	assign h      = (path_width > INSET_Q) ? ((path_width - INSET_Q) >> 1) : '0;
	assign mag_xz = job_q.horiz ? h : hp;

	assign x0e = POS_W'(job_q.x0);
	assign z0e = POS_W'(job_q.z0);
	assign xm  = x0e + POS_W'(hp);
	assign zm  = z0e + POS_W'(hp);
	assign xr  = x0e + POS_W'(path_width);
	assign zf  = z0e + POS_W'(path_width);

	always_comb begin
		cx = xm;
		cy = POS_W'(hh);
		cz = zm;
		case (dir)
			DIR_TOP:    cy = '0;
			DIR_BOTTOM: cy = POS_W'(wall_height);
			DIR_BACK:   cz = z0e;
			DIR_FRONT:  cz = zf;
			DIR_LEFT:   cx = x0e;
			DIR_RIGHT:  cx = xr;
			default:    cx = xm;
		endcase
	end

	assign sg = corner_sign(dir, k_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jv_q           <= 1'b0;
			k_q            <= 2'd0;
			vcount_q       <= '0;
			va_valid_q     <= 1'b0;
			vert_out.valid <= 1'b0;
		end else begin
			if (issue) begin
				k_q <= k_q + 2'd1;
				if (last_v)
					jv_q <= 1'b0;
				vcount_q <= (last_v && job_q.clear) ? '0 : vcount_q + 1'b1;
			end
			// A job with no faces still ends the mesh when it carries the clear.
			if (job_valid && job_ready) begin
				if (job.mask != 4'b0000) begin
					jv_q <= 1'b1;
					k_q  <= 2'd0;
				end else if (job.clear)
					vcount_q <= '0;
			end
			if (va_take)
				va_valid_q <= issue;
			if (out_en)
				vert_out.valid <= va_valid_q;
		end
	end

	always_ff @(posedge clk) begin
		if (issue && k_q == 2'd3)
			job_q.mask <= rest;
		if (job_valid && job_ready && job.mask != 4'b0000)
			job_q <= job;
		if (va_take) begin
			va_dir_q    <= dir;
			va_corner_q <= k_q;
			va_cx_q     <= cx;
			va_cy_q     <= cy;
			va_cz_q     <= cz;
			va_ox_q     <= signed_off(sg.sx, mag_xz);
			va_oy_q     <= signed_off(sg.sy, job_q.horiz ? h : hh);
			va_oz_q     <= signed_off(sg.sz, mag_xz);
			va_vnum_q   <= vcount_q;
			va_last_q   <= last_v;
		end
		if (out_en) begin
			vert_out.face_dir      <= va_dir_q;
			vert_out.corner        <= va_corner_q;
			vert_out.pos_x         <= clamp_pos(va_cx_q, va_ox_q);
			vert_out.pos_y         <= clamp_pos(va_cy_q, va_oy_q);
			vert_out.pos_z         <= clamp_pos(va_cz_q, va_oz_q);
			vert_out.vertex_number <= va_vnum_q;
			vert_out.last_of_item  <= va_last_q;
		end
	end
endmodule
`default_nettype wire

@@ rtl/core/grid_face_culling_mesher.sv @@
// Grid mesher. Cells enter on cell_in in raster order (req_type 0); after the
// last row, one drain transfer (req_type 1) per column meshes the final row.
// Each open cell produces quads of four vertices on vert_out, one vertex per
// transfer, the last vertex of an item flagged by last_of_item.
// Configuration is written through cfg_we / cfg_index / cfg_wdata while idle;
// the user must keep to this, the block does not enforce it. A vertex passes
// the stage-one, job, vertex and output registers. Throughput, while nothing
// stalls: one vertex per cycle, four per quad (up to sixteen for a wall cell
// with four wall neighbors); items that emit nothing go at one per cycle.
// The line store is a single 256 x 3 bit memory, one read-modify-write per
// cell; a back-to-back access to the same column is forwarded.
// Reset restores register defaults and clears row, column and vertex count;
// the line store is not cleared, since raster order writes every entry before
// it is read. A stalled receiver holds the output register and the pipeline
// backs up to cell_in.ready; nothing is dropped.
`default_nettype none
module grid_face_culling_mesher (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [gfm_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [gfm_pkg::CFG_W-1:0]      cfg_wdata,
	gfm_in_if.sink                         cell_in,
	gfm_out_if.source                      vert_out
);
	import gfm_pkg::*;

	logic [DIM_W-1:0]  grid_cols_q, grid_rows_q;
	logic [Q_W-1:0]    path_width_q, wall_height_q;
	logic [KIND_W-1:0] mesh_kind_q;

	logic [DIM_W-1:0]  row_pos_q;
	logic [COL_W-1:0]  col_pos_q;

	logic [DIM_W-1:0]  cols, rows, rp, r9, col_nxt;
	logic [COL_W-1:0]  cp;
	logic              accept, is_cell, eff_cell, eff_drain, wrap;

	logic                 s1_valid_q, s1_adv;
	logic                 mesh_s1, wr_s1, wall_s1, below_s1, clear_s1;
	logic                 rgt0_s1, cgt0_s1, rok_s1;
	logic [ROW_IDX_W-1:0] r_s1;
	logic [COL_W-1:0]     c_s1;
	logic [1:0]           m_s1, widx_s1;
	logic [WORD_W-1:0]    prev_word_q;

	logic [WORD_W-1:0] rd_a, rd_b, new_word;
	logic [1:0]        m_up;
	logic              self_wall, nb_back, nb_front, nb_left, nb_right, job_ready;
	job_t              job;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_cols_q   <= 9'd16;
			grid_rows_q   <= 9'd16;
			path_width_q  <= 24'd65536;
			wall_height_q <= 24'd65536;
			mesh_kind_q   <= KIND_WALL;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRID_COLS:   grid_cols_q   <= cfg_wdata[DIM_W-1:0];
				CFG_GRID_ROWS:   grid_rows_q   <= cfg_wdata[DIM_W-1:0];
				CFG_PATH_WIDTH:  path_width_q  <= cfg_wdata[Q_W-1:0];
				CFG_WALL_HEIGHT: wall_height_q <= cfg_wdata[Q_W-1:0];
				CFG_MESH_KIND:   mesh_kind_q   <= cfg_wdata[KIND_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (grid_cols_q == '0)
			cols = DIM_W'(1);
		else if (grid_cols_q > DIM_W'(MAX_COLS))
			cols = DIM_W'(MAX_COLS);
		else
			cols = grid_cols_q;
		if (grid_rows_q == '0)
			rows = DIM_W'(1);
		else if (grid_rows_q > DIM_W'(MAX_ROWS))
			rows = DIM_W'(MAX_ROWS);
		else
			rows = grid_rows_q;
	end

	// A resized grid pulls the position back into range before use.
	assign rp        = (row_pos_q > rows) ? rows : row_pos_q;
	assign cp        = (DIM_W'(col_pos_q) >= cols) ? '0 : col_pos_q;
	assign col_nxt   = DIM_W'(cp) + DIM_W'(1);
	assign wrap      = col_nxt >= cols;
	assign is_cell   = cell_in.req_type == REQ_CELL;
	assign eff_cell  = is_cell && rp < rows;
	assign eff_drain = !is_cell && rp >= rows;
	assign r9        = eff_cell ? rp - DIM_W'(1) : rows - DIM_W'(1);

	assign s1_adv        = s1_valid_q && job_ready;
	assign cell_in.ready = !s1_valid_q || job_ready;
	assign accept        = cell_in.valid && cell_in.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_pos_q  <= '0;
			col_pos_q  <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				row_pos_q  <= rp;
				col_pos_q  <= cp;
				s1_valid_q <= eff_cell || eff_drain;
				if (eff_cell || eff_drain)
					col_pos_q <= wrap ? '0 : col_nxt[COL_W-1:0];
				if (eff_cell && wrap)
					row_pos_q <= rp + DIM_W'(1);
				if (eff_drain && wrap)
					row_pos_q <= '0;
			end else if (s1_adv)
				s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mesh_s1  <= eff_drain || (eff_cell && rp != '0);
			wr_s1    <= eff_cell;
			wall_s1  <= cell_in.cell_is_wall;
			below_s1 <= eff_cell;
			clear_s1 <= eff_drain && wrap;
			r_s1     <= r9[ROW_IDX_W-1:0];
			c_s1     <= cp;
			m_s1     <= mod3(r9);
			widx_s1  <= mod3(rp);
			rgt0_s1  <= r9[ROW_IDX_W-1:0] != '0;
			cgt0_s1  <= cp != '0;
			rok_s1   <= col_nxt < cols;
		end
		if (s1_adv)
			prev_word_q <= wr_s1 ? new_word : rd_a;
	end

	gfm_line_store u_store (
		.clk       (clk),
		.rd_en     (accept),
		.rd_addr_a (cp),
		.rd_addr_b (col_nxt[COL_W-1:0]),
		.wr_en     (s1_adv && wr_s1),
		.wr_addr   (c_s1),
		.wr_data   (new_word),
		.rd_data_a (rd_a),
		.rd_data_b (rd_b)
	);

	always_comb begin
		new_word = rd_a;
		case (widx_s1)
			2'd0:    new_word[0] = wall_s1;
			2'd1:    new_word[1] = wall_s1;
			default: new_word[2] = wall_s1;
		endcase
	end

	// Row above the meshed row sits one slot back modulo three.
	assign m_up      = (m_s1 == 2'd0) ? 2'd2 : m_s1 - 2'd1;
	assign self_wall = word_bit(rd_a, m_s1);
	assign nb_back   = rgt0_s1 && word_bit(rd_a, m_up);
	assign nb_front  = below_s1 && wall_s1;
	assign nb_left   = cgt0_s1 && word_bit(prev_word_q, m_s1);
	assign nb_right  = rok_s1 && word_bit(rd_b, m_s1);

	always_comb begin
		job.horiz = 1'b0;
		job.hdir  = (mesh_kind_q == KIND_FLOOR) ? DIR_TOP : DIR_BOTTOM;
		job.mask  = 4'b0000;
		case (mesh_kind_q)
			KIND_FLOOR, KIND_CEIL: begin
				job.horiz = 1'b1;
				job.mask  = 4'b0001;
			end
			KIND_WALL: job.mask = {nb_right, nb_left, nb_front, nb_back};
			default:   job.mask = 4'b0000;
		endcase
		if (!mesh_s1 || self_wall)
			job.mask = 4'b0000;
		job.x0    = X0_W'(c_s1) * X0_W'(path_width_q);
		job.z0    = X0_W'(r_s1) * X0_W'(path_width_q);
		job.clear = clear_s1;
	end

	gfm_emitter u_emit (
		.clk         (clk),
		.arst_n      (arst_n),
		.job_valid   (s1_valid_q),
		.job         (job),
		.job_ready   (job_ready),
		.path_width  (path_width_q),
		.wall_height (wall_height_q),
		.vert_out    (vert_out)
	);
endmodule
`default_nettype wire

@@ sim/grid_face_culling_mesher_test.sv @@
`default_nettype none
module grid_face_culling_mesher_test;
	import gfm_pkg::*;

	localparam logic REQ_DRAIN = 1'b1;
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;
	localparam int STORE_COLS = 256;
	localparam int IDLE_LIMIT = 6000;
	localparam int SETTLE_CYCLES = 24;
	localparam int MAX_PRINTS = 40;
	localparam longint COORD_MAX = 64'd17179869183;
	localparam longint INSET = 66;

	typedef struct {
		logic req_type;
		logic cell_is_wall;
	} grid_item_t;

	typedef struct {
		logic [DIR_W-1:0]  face_dir;
		logic [1:0]        corner;
		logic [POS_W-1:0]  pos_x;
		logic [POS_W-1:0]  pos_y;
		logic [POS_W-1:0]  pos_z;
		logic [VNUM_W-1:0] vertex_number;
		logic              last_of_item;
	} vertex_t;

	// Offset signs per face and corner, as x, y, z.
	int offset_sign [6][4][3] = '{
		'{'{-1, 0, 1}, '{1, 0, 1}, '{1, 0, -1}, '{-1, 0, -1}},
		'{'{-1, 0, -1}, '{1, 0, -1}, '{1, 0, 1}, '{-1, 0, 1}},
		'{'{0, 1, -1}, '{0, 1, 1}, '{0, -1, 1}, '{0, -1, -1}},
		'{'{0, 1, 1}, '{0, 1, -1}, '{0, -1, -1}, '{0, -1, 1}},
		'{'{-1, 1, 0}, '{1, 1, 0}, '{1, -1, 0}, '{-1, -1, 0}},
		'{'{1, 1, 0}, '{-1, 1, 0}, '{-1, -1, 0}, '{1, -1, 0}}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;

	gfm_in_if cin();
	gfm_out_if vout();

	grid_face_culling_mesher uut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.cell_in(cin),
		.vert_out(vout)
	);

	always #4 clk = ~clk;

	// Mirror of the block's state.
	bit line_mem [3*STORE_COLS];
	int col_pos, row_pos;
	logic [VNUM_W-1:0] vert_count;
	int grid_cols_r, grid_rows_r;
	longint path_width_r, wall_height_r;
	logic [KIND_W-1:0] mesh_kind_r;

	grid_item_t pending_items[$];
	vertex_t expected_verts[$];
	vertex_t cell_verts[$];

	int errors, prints;
	int cells_sent, drains_sent, verts_checked, meshes_done;
	bit no_gaps;
	int hold_request;
	int idle_cycles;

	task automatic report(input string msg);
		errors++;
		if (prints < MAX_PRINTS) begin
			prints++;
			$display("mismatch: %s", msg);
		end
	endtask

	function automatic logic [POS_W-1:0] clip_coord(input longint v);
		if (v < 0)
			return '0;
		if (v > COORD_MAX)
			return POS_W'(COORD_MAX);
		return POS_W'(v);
	endfunction

	function automatic bit wall_at(input int row, input int col);
		return line_mem[(row % 3) * STORE_COLS + (col % STORE_COLS)];
	endfunction

	function automatic void emit_quad(input logic [DIR_W-1:0] dir, input longint cx,
			input longint cy, input longint cz, input longint a, input longint b);
		longint zmag;
		vertex_t v;
		zmag = (dir < 2) ? b : a;
		for (int k = 0; k < 4; k++) begin
			v.face_dir = dir;
			v.corner = k[1:0];
			v.pos_x = clip_coord(cx + offset_sign[dir][k][0] * a);
			v.pos_y = clip_coord(cy + offset_sign[dir][k][1] * b);
			v.pos_z = clip_coord(cz + offset_sign[dir][k][2] * zmag);
			v.vertex_number = vert_count;
			v.last_of_item = 1'b0;
			cell_verts.insert(cell_verts.size(), v);
			vert_count = vert_count + 1'b1;
		end
	endfunction

	function automatic void mesh_open_cell(input int r, input int c, input int cols,
			input bit has_below, input bit below_wall);
		longint s, h, hp, hh, x0, z0;
		vertex_t v;
		cell_verts.delete();
		if (wall_at(r, c))
			return;
		if (mesh_kind_r == KIND_FLOOR || mesh_kind_r == KIND_CEIL) begin
			s = (path_width_r > INSET) ? path_width_r - INSET : 0;
			h = s >>> 1;
			x0 = ((2 * c + 1) * path_width_r) >>> 1;
			z0 = ((2 * r + 1) * path_width_r) >>> 1;
			if (mesh_kind_r == KIND_FLOOR)
				emit_quad(DIR_TOP, x0, 0, z0, h, h);
			else
				emit_quad(DIR_BOTTOM, x0, wall_height_r, z0, h, h);
		end else if (mesh_kind_r == KIND_WALL) begin
			hp = path_width_r >>> 1;
			hh = wall_height_r >>> 1;
			x0 = c * path_width_r;
			z0 = r * path_width_r;
			if (r > 0 && wall_at(r - 1, c))
				emit_quad(DIR_BACK, x0 + hp, hh, z0, hp, hh);
			if (has_below && below_wall)
				emit_quad(DIR_FRONT, x0 + hp, hh, z0 + path_width_r, hp, hh);
			if (c > 0 && wall_at(r, c - 1))
				emit_quad(DIR_LEFT, x0, hh, z0 + hp, hp, hh);
			if (c + 1 < cols && wall_at(r, c + 1))
				emit_quad(DIR_RIGHT, x0 + path_width_r, hh, z0 + hp, hp, hh);
		end
		if (cell_verts.size() > 0)
			cell_verts[cell_verts.size() - 1].last_of_item = 1'b1;
		while (cell_verts.size() > 0) begin
			v = cell_verts.pop_front();
			expected_verts.insert(expected_verts.size(), v);
		end
	endfunction

	function automatic void predict_item(input logic req, input logic wall);
		int cols, rows;
		cols = (grid_cols_r < 1) ? 1 : (grid_cols_r > STORE_COLS ? STORE_COLS : grid_cols_r);
		rows = (grid_rows_r < 1) ? 1 : (grid_rows_r > 256 ? 256 : grid_rows_r);
		if (row_pos > rows)
			row_pos = rows;
		if (col_pos >= cols)
			col_pos = 0;
		if (req == REQ_CELL) begin
			if (row_pos >= rows)
				return;
			line_mem[(row_pos % 3) * STORE_COLS + col_pos] = wall;
			if (row_pos > 0)
				mesh_open_cell(row_pos - 1, col_pos, cols, 1'b1, wall);
			col_pos++;
			if (col_pos >= cols) begin
				col_pos = 0;
				row_pos++;
			end
		end else begin
			if (row_pos < rows)
				return;
			mesh_open_cell(rows - 1, col_pos, cols, 1'b0, 1'b0);
			col_pos++;
			if (col_pos >= cols) begin
				col_pos = 0;
				row_pos = 0;
				vert_count = '0;
				meshes_done++;
			end
		end
	endfunction

	// Sender: bursts of random length separated by random gaps.
	int burst_left, gap_left;
	always @(posedge clk) begin
		grid_item_t it;
		if (arst_n) begin
			if (cin.valid && cin.ready) begin
				predict_item(cin.req_type, cin.cell_is_wall);
				if (cin.req_type == REQ_CELL)
					cells_sent++;
				else
					drains_sent++;
			end
			if (!(cin.valid && !cin.ready)) begin
				if (gap_left > 0 && !no_gaps) begin
					gap_left <= gap_left - 1;
					cin.valid <= 1'b0;
				end else if (pending_items.size() > 0) begin
					it = pending_items.pop_front();
					cin.valid <= 1'b1;
					cin.req_type <= it.req_type;
					cin.cell_is_wall <= it.cell_is_wall;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(1, 20);
						gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end else begin
						burst_left <= burst_left - 1;
						gap_left <= 0;
					end
				end else begin
					cin.valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: stall pattern in a few modes, plus a long hold on request.
	int stall_mode, hold_left;
	always @(posedge clk) begin
		vertex_t got, want;
		string diff;
		if (arst_n) begin
			if (vout.valid && vout.ready) begin
				got.face_dir = vout.face_dir;
				got.corner = vout.corner;
				got.pos_x = vout.pos_x;
				got.pos_y = vout.pos_y;
				got.pos_z = vout.pos_z;
				got.vertex_number = vout.vertex_number;
				got.last_of_item = vout.last_of_item;
				if (expected_verts.size() == 0) begin
					report($sformatf("vertex with nothing expected: face %0d corner %0d",
						got.face_dir, got.corner));
				end else begin
					want = expected_verts.pop_front();
					verts_checked++;
					diff = "";
					if (got.face_dir !== want.face_dir)
						diff = {diff, $sformatf(" face %0d/%0d", got.face_dir, want.face_dir)};
					if (got.corner !== want.corner)
						diff = {diff, $sformatf(" corner %0d/%0d", got.corner, want.corner)};
					if (got.pos_x !== want.pos_x)
						diff = {diff, $sformatf(" x %0h/%0h", got.pos_x, want.pos_x)};
					if (got.pos_y !== want.pos_y)
						diff = {diff, $sformatf(" y %0h/%0h", got.pos_y, want.pos_y)};
					if (got.pos_z !== want.pos_z)
						diff = {diff, $sformatf(" z %0h/%0h", got.pos_z, want.pos_z)};
					if (got.vertex_number !== want.vertex_number)
						diff = {diff, $sformatf(" vnum %0d/%0d", got.vertex_number,
							want.vertex_number)};
					if (got.last_of_item !== want.last_of_item)
						diff = {diff, $sformatf(" last %0b/%0b", got.last_of_item,
							want.last_of_item)};
					if (diff != "")
						report({"vertex (got/expected):", diff});
				end
			end
			if ($urandom_range(0, 63) == 0)
				stall_mode = $urandom_range(0, 2);
			if (hold_request > 0) begin
				hold_left <= hold_request - 1;
				hold_request = 0;
				vout.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				vout.ready <= 1'b0;
			end else begin
				case (stall_mode)
					0: vout.ready <= 1'b1;
					1: vout.ready <= ($urandom_range(0, 3) != 0);
					default: vout.ready <= 1'($urandom_range(0, 1));
				endcase
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((cin.valid && cin.ready) || (vout.valid && vout.ready) || !arst_n)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
			$display("TEST FAILED");
			$finish;
		end
	end

	task automatic push_cell(input bit wall);
		grid_item_t it;
		it.req_type = REQ_CELL;
		it.cell_is_wall = wall;
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic push_drain();
		grid_item_t it;
		it.req_type = REQ_DRAIN;
		it.cell_is_wall = 1'($urandom_range(0, 1));
		pending_items.insert(pending_items.size(), it);
	endtask

	task automatic wait_idle();
		@(negedge clk);
		while (pending_items.size() > 0 || cin.valid || expected_verts.size() > 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		case (idx)
			CFG_GRID_COLS: grid_cols_r = int'(val[DIM_W-1:0]);
			CFG_GRID_ROWS: grid_rows_r = int'(val[DIM_W-1:0]);
			CFG_PATH_WIDTH: path_width_r = longint'(val);
			CFG_WALL_HEIGHT: wall_height_r = longint'(val);
			CFG_MESH_KIND: mesh_kind_r = val[KIND_W-1:0];
			default: ;
		endcase
	endtask

	task automatic setup_grid(input int cols, input int rows, input logic [CFG_W-1:0] pw,
			input logic [CFG_W-1:0] wh, input logic [KIND_W-1:0] kind);
		write_reg(CFG_GRID_COLS, CFG_W'(cols));
		write_reg(CFG_GRID_ROWS, CFG_W'(rows));
		write_reg(CFG_PATH_WIDTH, pw);
		write_reg(CFG_WALL_HEIGHT, wh);
		write_reg(CFG_MESH_KIND, CFG_W'(kind));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// One whole mesh with random content; early drains and extra cells as noise.
	task automatic random_mesh(input int cols, input int rows, input int wall_pct,
			input bit split);
		int n;
		n = cols * rows;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 19) == 0)
				push_drain();
			push_cell($urandom_range(0, 99) < wall_pct);
			if (split && i == n / 2)
				wait_idle();
		end
		if ($urandom_range(0, 2) == 0)
			push_cell(1'($urandom_range(0, 1)));
		for (int i = 0; i < cols; i++)
			push_drain();
		wait_idle();
	endtask

	initial begin
		int rand_cells, cols, rows, pw;
		logic [KIND_W-1:0] kind;
		cin.valid = 1'b0;
		cin.req_type = REQ_CELL;
		cin.cell_is_wall = 1'b0;
		vout.ready = 1'b0;
		grid_cols_r = 16;
		grid_rows_r = 16;
		path_width_r = 65536;
		wall_height_r = 65536;
		mesh_kind_r = KIND_WALL;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// Open cell ringed by walls gives all four wall faces; early drain and
		// an extra cell are both ignored.
		setup_grid(3, 3, 24'h018000, 24'h030000, KIND_WALL);
		push_drain();
		push_cell(1); push_cell(1); push_cell(1);
		push_cell(1); push_cell(0); push_cell(1);
		push_cell(1); push_cell(1); push_cell(1);
		push_cell(0);
		push_drain(); push_drain(); push_drain();
		wait_idle();
		// Zero sizes clamp to one cell; zero pitch gives a zero inset quad.
		setup_grid(0, 0, 24'd0, 24'd0, KIND_FLOOR);
		push_cell(0);
		push_drain();
		wait_idle();
		// Full-scale pitch and height, ceiling faces.
		setup_grid(2, 1, 24'hFFFFFF, 24'hFFFFFF, KIND_CEIL);
		push_cell(0); push_cell(0);
		push_drain(); push_drain();
		wait_idle();
		// Unused kind stores and counts cells but emits nothing.
		setup_grid(2, 2, 24'd67, 24'd1, KIND_NONE);
		push_cell(0); push_cell(1); push_cell(0); push_cell(0);
		push_drain(); push_drain();
		wait_idle();

		// Random meshes; the first one pauses mid-way and sees a long hold.
		rand_cells = 0;
		while (rand_cells < 55) begin
			cols = $urandom_range(1, 7);
			rows = $urandom_range(1, 5);
			case ($urandom_range(0, 3))
				0: pw = $urandom_range(0, 200);
				1: pw = $urandom_range(0, 24'hFFFFFF);
				default: pw = $urandom_range(24'h8000, 24'h30000);
			endcase
			kind = ($urandom_range(0, 9) == 0) ? KIND_NONE :
				(($urandom_range(0, 1) == 0) ? KIND_WALL : KIND_W'($urandom_range(0, 1)));
			setup_grid(cols, rows, CFG_W'(pw), CFG_W'($urandom_range(0, 24'hFFFFFF)), kind);
			if (rand_cells == 0) begin
				@(negedge clk);
				hold_request = 300;
			end
			no_gaps = ($urandom_range(0, 3) == 0);
			random_mesh(cols, rows, (kind == KIND_WALL) ? 45 : 30, rand_cells == 0);
			rand_cells += cols * rows + cols;
		end

		// A long receiver hold on a busy wall mesh fills the block and stalls its input.
		no_gaps = 1'b1;
		setup_grid(8, 3, 24'h010000, 24'h020000, KIND_WALL);
		@(negedge clk);
		hold_request = 300;
		random_mesh(8, 3, 50, 1'b0);
		no_gaps = 1'b0;

		$display("covered %0d cells, %0d drains, %0d meshes, %0d vertices checked",
			cells_sent, drains_sent, meshes_done, verts_checked);
		$display("floor, ceiling, wall and unused kinds on grids of one to eight columns");
		if (errors == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches", errors);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
`default_nettype wire
